// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the nearest clock divider search top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is low.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression is never true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_ALWAYS(label, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/core/ncds_pkg.sv =====
// Types and constants shared by the nearest clock divider search block.
package ncds_pkg;

  localparam int unsigned FIELD_BITS = 32;

  typedef struct packed {
    logic [FIELD_BITS-1:0] source_rate;
    logic [FIELD_BITS-1:0] wanted_rate;
  } in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] rounded_rate;
    logic [FIELD_BITS-1:0] chosen_divider;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/ncds_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ncds_divider import ncds_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output div_stat_t    stat,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int unsigned CNT_BITS = $clog2(W + 1);

  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [W-1:0]        rem_r, rem_nxt;
  logic [W-1:0]        quo_r, quo_nxt;
  logic [W-1:0]        dvs_r, dvs_nxt;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (go) begin
      cnt_nxt = CNT_BITS'(W);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CNT_BITS'(1);
      rem_nxt  = fits ? diff[W-1:0] : trial[W-1:0];
      quo_nxt  = {quo_r[W-2:0], fits};
      done_nxt = (cnt_r == CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/core/nearest_clock_divider_search.sv =====
// Top level of the nearest clock divider search: control sequencer around one serial divider.
// Work per request: a zero request is answered without a division; an exact divisor
//   or a request above the parent takes one division; else that division, plus one per trial
//   divisor 1..floor(sqrt(parent))+1, two fold steps per divisor hit and 2-3 closing divisions.
// One item at a time; the next start is taken at the edge that ends the result beat.
// Reset: synchronous, active low; drops busy and out_valid. The receiver cannot stall the strobe.
module nearest_clock_divider_search import ncds_pkg::*; #(
  parameter int unsigned RATE_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

`include "assert_macros.svh"

  localparam int unsigned W = RATE_BITS;

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_QDIV  = 4'd1;   // issue parent / request
  localparam logic [3:0] S_QWAIT = 4'd2;
  localparam logic [3:0] S_SDIV  = 4'd3;   // issue parent / trial divisor
  localparam logic [3:0] S_SWAIT = 4'd4;
  localparam logic [3:0] S_UPD_D = 4'd5;   // fold the small divisor of a pair
  localparam logic [3:0] S_UPD_E = 4'd6;   // fold the large divisor of a pair
  localparam logic [3:0] S_DQ    = 4'd7;   // rate of the quotient candidate
  localparam logic [3:0] S_DQW   = 4'd8;
  localparam logic [3:0] S_DU    = 4'd9;   // rate of the upper candidate
  localparam logic [3:0] S_DUW   = 4'd10;
  localparam logic [3:0] S_DL    = 4'd11;  // rate of the lower candidate
  localparam logic [3:0] S_DLW   = 4'd12;
  localparam logic [3:0] S_PICK  = 4'd13;

  logic [3:0]   state_r, state_nxt;
  logic [W-1:0] p_r, p_nxt;     // parent rate
  logic [W-1:0] r_r, r_nxt;     // requested rate
  logic [W-1:0] q_r, q_nxt;     // floor quotient
  logic [W-1:0] d_r, d_nxt;     // trial divisor
  logic [W-1:0] e_r, e_nxt;     // cofactor p / d
  logic [W-1:0] up_r, up_nxt;   // smallest divisor above q so far
  logic [W-1:0] lo_r, lo_nxt;   // largest divisor below q so far, zero if none
  logic [W-1:0] rq_r, rq_nxt;   // candidate rates
  logic [W-1:0] ru_r, ru_nxt;
  logic [W-1:0] rl_r, rl_nxt;
  logic [W-1:0] dq_r, dq_nxt;   // candidate distances
  logic [W-1:0] du_r, du_nxt;
  logic [W-1:0] dl_r, dl_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_t         out_data_r, out_data_nxt;

  logic         emit;
  logic [W-1:0] emit_rate;
  logic [W-1:0] emit_div;

  logic [FIELD_BITS+W-1:0] src_ext, want_ext;
  logic [FIELD_BITS+W-1:0] rate_ext, div_ext;

  logic         div_go;
  logic [W-1:0] div_divisor;
  div_stat_t    div_stat;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic         div_wait;

  logic [W-1:0] dist_a, dist_b, dist_ab;

  // Fit the 32-bit fields to the datapath width, either way.
  assign src_ext  = {{W{1'b0}}, in_data.source_rate};
  assign want_ext = {{W{1'b0}}, in_data.wanted_rate};
  assign rate_ext = {{FIELD_BITS{1'b0}}, emit_rate};
  assign div_ext  = {{FIELD_BITS{1'b0}}, emit_div};

  // Issue a division from each issue state; the dividend is always the parent.
  // A zero request needs no division, so leave the divider idle for it.
  always_comb begin
    div_go      = 1'b1;
    div_divisor = r_r;
    case (state_r)
      S_QDIV:  div_go      = (r_r != '0);
      S_SDIV:  div_divisor = d_r;
      S_DQ:    div_divisor = q_r;
      S_DU:    div_divisor = up_r;
      S_DL:    div_divisor = lo_r;
      default: div_go      = 1'b0;
    endcase
  end

  ncds_divider #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (p_r),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Absolute distance between a candidate rate and the request.
  assign dist_a  = div_quo;
  assign dist_b  = r_r;
  assign dist_ab = (dist_a >= dist_b) ? (dist_a - dist_b) : (dist_b - dist_a);

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    r_nxt     = r_r;
    q_nxt     = q_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    up_nxt    = up_r;
    lo_nxt    = lo_r;
    rq_nxt    = rq_r;
    ru_nxt    = ru_r;
    rl_nxt    = rl_r;
    dq_nxt    = dq_r;
    du_nxt    = du_r;
    dl_nxt    = dl_r;
    emit      = 1'b0;
    emit_rate = '0;
    emit_div  = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          p_nxt     = src_ext[W-1:0];
          r_nxt     = want_ext[W-1:0];
          state_nxt = S_QDIV;
        end
      end

      S_QDIV: begin
        // A zero request is gated: answer at once without a division.
        if (r_r == '0) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_QWAIT;
        end
      end

      S_QWAIT: begin
        if (div_stat.done) begin
          if (div_rem == '0) begin
            // Exact divisor: pass the request through.
            emit      = 1'b1;
            emit_rate = r_r;
            emit_div  = div_quo;
            state_nxt = S_IDLE;
          end else if (div_quo == '0) begin
            // Request above the parent: divide by one.
            emit      = 1'b1;
            emit_rate = p_r;
            emit_div  = W'(1);
            state_nxt = S_IDLE;
          end else begin
            q_nxt     = div_quo;
            d_nxt     = W'(1);
            up_nxt    = p_r;
            lo_nxt    = '0;
            state_nxt = S_SDIV;
          end
        end
      end

      S_SDIV: state_nxt = S_SWAIT;

      S_SWAIT: begin
        if (div_stat.done) begin
          e_nxt = div_quo;
          if (d_r > div_quo) begin
            // Past the square root: the search is complete.
            state_nxt = S_DQ;
          end else if (div_rem == '0) begin
            state_nxt = S_UPD_D;
          end else begin
            d_nxt     = d_r + W'(1);
            state_nxt = S_SDIV;
          end
        end
      end

      S_UPD_D: begin
        if (d_r > q_r && d_r < up_r) up_nxt = d_r;
        if (d_r < q_r && d_r > lo_r) lo_nxt = d_r;
        state_nxt = S_UPD_E;
      end

      S_UPD_E: begin
        if (e_r > q_r && e_r < up_r) up_nxt = e_r;
        if (e_r < q_r && e_r > lo_r) lo_nxt = e_r;
        d_nxt     = d_r + W'(1);
        state_nxt = S_SDIV;
      end

      S_DQ: state_nxt = S_DQW;

      S_DQW: begin
        if (div_stat.done) begin
          rq_nxt    = div_quo;
          dq_nxt    = dist_ab;
          state_nxt = S_DU;
        end
      end

      S_DU: state_nxt = S_DUW;

      S_DUW: begin
        if (div_stat.done) begin
          ru_nxt    = div_quo;
          du_nxt    = dist_ab;
          // Skip the lower candidate when no divisor lies below the quotient.
          state_nxt = (lo_r != '0) ? S_DL : S_PICK;
        end
      end

      S_DL: state_nxt = S_DLW;

      S_DLW: begin
        if (div_stat.done) begin
          rl_nxt    = div_quo;
          dl_nxt    = dist_ab;
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        // Ties go to the upper divider, then the lower, then the quotient.
        emit      = 1'b1;
        state_nxt = S_IDLE;
        if (lo_r != '0) begin
          if (du_r <= dl_r && du_r <= dq_r) begin
            emit_rate = ru_r;
            emit_div  = up_r;
          end else if (dl_r <= dq_r) begin
            emit_rate = rl_r;
            emit_div  = lo_r;
          end else begin
            emit_rate = rq_r;
            emit_div  = q_r;
          end
        end else if (du_r <= dq_r) begin
          emit_rate = ru_r;
          emit_div  = up_r;
        end else begin
          emit_rate = rq_r;
          emit_div  = q_r;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result beat for one cycle behind a register.
  always_comb begin
    out_valid_nxt = emit;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_data_nxt.rounded_rate   = rate_ext[FIELD_BITS-1:0];
      out_data_nxt.chosen_divider = div_ext[FIELD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r        <= p_nxt;
    r_r        <= r_nxt;
    q_r        <= q_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    up_r       <= up_nxt;
    lo_r       <= lo_nxt;
    rq_r       <= rq_nxt;
    ru_r       <= ru_nxt;
    rl_r       <= rl_nxt;
    dq_r       <= dq_nxt;
    du_r       <= du_nxt;
    dl_r       <= dl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign div_wait = (state_r == S_QWAIT) || (state_r == S_SWAIT) || (state_r == S_DQW) ||
                    (state_r == S_DUW) || (state_r == S_DLW);

  // A new division never starts while the divider is still stepping.
  `ASSERT_NEVER(a_div_go_idle, clk, rst_n, div_go && div_stat.busy, "division issued while busy")

  // Result beats never come in consecutive cycles.
  `ASSERT_ALWAYS(a_out_single, clk, rst_n, out_valid |=> !out_valid, "back to back result beats")

  // A finished division always lands in a wait state.
  `ASSERT_ALWAYS(a_done_wait, clk, rst_n, div_stat.done |-> div_wait, "done outside a wait state")

  // Every result beat follows a cycle in which the sequencer was working.
  `ASSERT_ALWAYS(a_out_after_busy, clk, rst_n, $rose(out_valid) |-> $past(busy), "result beat without work")

endmodule

// ===== tb/tb_nearest_clock_divider_search.sv =====
// Self-checking testbench for the nearest clock divider search block.
`timescale 1ns / 1ps

module tb_nearest_clock_divider_search;
  import ncds_pkg::*;

  // Longest quiet stretch allowed: a 20-bit parent needs about 1024 trial divisors,
  // each a full serial division, so allow several times that.
  localparam int unsigned QUIET_LIMIT  = 400000;
  // Settle time after the last result.
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_BEATS = 120;

  typedef struct packed {
    in_t  stim;
    logic typed;
    out_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  out_t        expected_rates[$];
  plan_row_t   plan[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;

  nearest_clock_divider_search u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [63:0] rate_gap(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Work out the achievable rate closest to the request and the divider behind it.
  function automatic out_t nearest_rate(input in_t beat);
    logic [63:0] p, r, q, d, e, up, lo, gap_q, gap_up, gap_lo, rate, div;
    out_t res;
    p = {32'd0, beat.source_rate};
    r = {32'd0, beat.wanted_rate};
    if (r == 0) begin
      rate = 0;
      div  = 0;
    end else if (p % r == 0) begin
      rate = r;
      div  = p / r;
    end else if (r > p) begin
      rate = p;
      div  = 1;
    end else begin
      q  = p / r;
      up = p;
      lo = 0;
      // Walk divisor pairs (d, p/d) up to the square root of the parent.
      for (d = 1; d <= p / d; d++) begin
        if (p % d == 0) begin
          e = p / d;
          if (d > q && d < up) up = d;
          if (e > q && e < up) up = e;
          if (d < q && d > lo) lo = d;
          if (e < q && e > lo) lo = e;
        end
      end
      gap_q  = rate_gap(p / q, r);
      gap_up = rate_gap(r, p / up);
      if (lo != 0) begin
        gap_lo = rate_gap(p / lo, r);
        if (gap_up <= gap_lo && gap_up <= gap_q) div = up;
        else if (gap_lo <= gap_q) div = lo;
        else div = q;
      end else begin
        // No divisor below a quotient of one: skip the lower candidate.
        div = (gap_up <= gap_q) ? up : q;
      end
      rate = p / div;
    end
    res.rounded_rate   = rate[31:0];
    res.chosen_divider = div[31:0];
    return res;
  endfunction

  function automatic plan_row_t plan_row(input logic [31:0] src, input logic [31:0] wanted,
                                         input logic typed, input logic [31:0] rate,
                                         input logic [31:0] div);
    plan_row_t row;
    row.stim.source_rate   = src;
    row.stim.wanted_rate   = wanted;
    row.typed              = typed;
    row.want.rounded_rate  = rate;
    row.want.chosen_divider = div;
    return row;
  endfunction

  // Draw one request. Full-width parents go only with the cheap answers (gated, exact,
  // above the parent); the divisor search gets parents below 2^20 to bound latency.
  function automatic in_t random_request();
    in_t         beat;
    int unsigned sel;
    int unsigned k;
    int unsigned ceiling;
    sel = $urandom_range(99);
    if (sel < 8) begin
      beat.source_rate = $urandom();
      beat.wanted_rate = '0;
    end else if (sel < 18) begin
      beat.source_rate = $urandom_range(32'hFFFF_FFFE, 0);
      beat.wanted_rate = $urandom_range(32'hFFFF_FFFF, beat.source_rate + 1);
    end else if (sel < 30) begin
      k = $urandom_range(1) ? $urandom_range(64, 1) : ($urandom() >> $urandom_range(31, 0));
      if (k == 0) k = 1;
      beat.wanted_rate = $urandom_range(32'hFFFF_FFFF / k, 1);
      beat.source_rate = beat.wanted_rate * k;
    end else if (sel < 35) begin
      beat.source_rate = '0;
      beat.wanted_rate = $urandom();
    end else begin
      sel = $urandom_range(99);
      ceiling = (sel < 70) ? 4095 : (sel < 95) ? 65535 : 32'h000F_FFFF;
      beat.source_rate = $urandom_range(ceiling, 3);
      beat.wanted_rate = $urandom_range(1) ? $urandom_range(beat.source_rate, 2)
                                           : $urandom_range(16, 2);
    end
    return beat;
  endfunction

  // Offer one beat; drop start on idle cycles, which may land anywhere in the busy window.
  task automatic send_request(input in_t beat, input logic typed, input out_t want);
    logic taken;
    taken = 1'b0;
    in_data <= beat;
    while (!taken) begin
      start <= ($urandom_range(99) >= send_idle_pct);
      @(posedge clk);
      taken = start && !busy;
      if (!taken) @(negedge clk);
    end
    expected_rates.push_back(typed ? want : nearest_rate(beat));
    @(negedge clk);
  endtask

  // Results cannot be held off: check every strobe against the oldest expectation.
  always @(posedge clk) begin
    out_t exp_beat;
    if (rst_n && out_valid) begin
      if (expected_rates.size() == 0) begin
        $display("%0t: unexpected result beat rate=%h divider=%h", $time,
                 out_data.rounded_rate, out_data.chosen_divider);
        mismatches++;
      end else begin
        exp_beat = expected_rates.pop_front();
        if (out_data.rounded_rate !== exp_beat.rounded_rate) begin
          $display("%0t: rounded_rate expected %h actual %h", $time,
                   exp_beat.rounded_rate, out_data.rounded_rate);
          mismatches++;
        end
        if (out_data.chosen_divider !== exp_beat.chosen_divider) begin
          $display("%0t: chosen_divider expected %h actual %h", $time,
                   exp_beat.chosen_divider, out_data.chosen_divider);
          mismatches++;
        end
      end
    end
  end

  // Stop the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;

    // Directed rows: typed answers only where they are obvious.
    // Gated requests, with the largest and a zero parent.
    plan.push_back(plan_row(32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0, 32'h0));
    plan.push_back(plan_row(32'h0, 32'h0, 1'b1, 32'h0, 32'h0));
    // Zero parent: every request divides it, the divider reads zero.
    plan.push_back(plan_row(32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'h0));
    plan.push_back(plan_row(32'h0, 32'h1, 1'b1, 32'h1, 32'h0));
    // Exact divisors at the field extremes.
    plan.push_back(plan_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'h1));
    plan.push_back(plan_row(32'hFFFF_FFFF, 32'h1, 1'b1, 32'h1, 32'hFFFF_FFFF));
    plan.push_back(plan_row(32'hFFFF_FFFF, 32'h3, 1'b1, 32'h3, 32'h5555_5555));
    plan.push_back(plan_row(32'h8000_0000, 32'h0001_0000, 1'b1, 32'h0001_0000, 32'h8000));
    plan.push_back(plan_row(32'd1000, 32'd250, 1'b1, 32'd250, 32'd4));
    plan.push_back(plan_row(32'h2, 32'h1, 1'b1, 32'h1, 32'h2));
    plan.push_back(plan_row(32'h1, 32'h1, 1'b1, 32'h1, 32'h1));
    // Request above the parent: divider one.
    plan.push_back(plan_row(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 32'h1));
    plan.push_back(plan_row(32'h1, 32'hFFFF_FFFF, 1'b1, 32'h1, 32'h1));
    // Quotient of one, so no lower divisor exists.
    plan.push_back(plan_row(32'd10, 32'd6, 1'b0, 32'h0, 32'h0));
    plan.push_back(plan_row(32'd3, 32'd2, 1'b0, 32'h0, 32'h0));
    // Upper and quotient tie; the upper divider wins.
    plan.push_back(plan_row(32'd12, 32'd5, 1'b0, 32'h0, 32'h0));
    // Prime and composite parents: the quotient itself wins.
    plan.push_back(plan_row(32'd13, 32'd4, 1'b0, 32'h0, 32'h0));
    plan.push_back(plan_row(32'd7, 32'd2, 1'b0, 32'h0, 32'h0));
    plan.push_back(plan_row(32'd30, 32'd7, 1'b0, 32'h0, 32'h0));
    plan.push_back(plan_row(32'd1000, 32'd333, 1'b0, 32'h0, 32'h0));
    // Long search over a 20-bit parent.
    plan.push_back(plan_row(32'd1048573, 32'd7, 1'b0, 32'h0, 32'h0));
    plan.push_back(plan_row(32'h000F_FFFF, 32'd100, 1'b0, 32'h0, 32'h0));

    // Hold reset, then release it on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) send_request(plan[i].stim, plan[i].typed, plan[i].want);

    // Random beats in three idle phases: none, heavy, light. The result side has no
    // back-pressure, so only the sender idles.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 0 : (phase == 1) ? 64 : 11;
      for (n = 0; n < RANDOM_BEATS / 3; n++) send_request(random_request(), 1'b0, '0);
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for stray strobes.
    while (expected_rates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
